// ===== rtl/core/kle_pkg.sv =====
`default_nettype none
package kle_pkg;

  // Default geometry of the text store and of the visible window.
  localparam int MAX_LINES_DEF    = 64;
  localparam int LINE_CHARS_DEF   = 18;
  localparam int WINDOW_LINES_DEF = 6;

  // Fixed field widths of the stream payloads.
  localparam int MOD_W   = 8;
  localparam int KEY_W   = 8;
  localparam int RLINE_W = 6;
  localparam int RCOL_W  = 5;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 5;
  localparam int COUNT_W = 7;
  localparam int CHAR_W  = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [MOD_W-1:0] SHIFT_MASK = 8'h22;

  localparam logic [KEY_W-1:0] KEY_ORIGIN = 8'h4A;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h4F;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h50;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h51;
  localparam logic [KEY_W-1:0] KEY_UP     = 8'h52;
  localparam logic [KEY_W-1:0] MAP_SIZE   = 8'h4A;

  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ENTER = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACK  = 8'h08;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
    logic shift;
    logic put;
    logic crd;
    logic clamp;
    logic out_load;
  } kle_cmd_t;

  typedef struct packed {
    logic is_read;
    logic edit;
    logic shift_done;
  } kle_sts_t;

  // Character for a usage code below MAP_SIZE, plain or shifted.
  function automatic logic [CHAR_W-1:0] key_char(input logic shifted,
                                                 input logic [KEY_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CH_NONE;
    if (code >= 8'h04 && code <= 8'h1D) begin
      ch = (shifted ? 8'h41 : 8'h61) + (code - 8'h04);
    end else if (!shifted && code >= 8'h1E && code <= 8'h26) begin
      ch = 8'h31 + (code - 8'h1E);
    end else begin
      case (code)
        8'h1E: ch = 8'h21;
        8'h1F: ch = 8'h40;
        8'h20: ch = 8'h23;
        8'h21: ch = 8'h24;
        8'h22: ch = 8'h25;
        8'h23: ch = 8'h5E;
        8'h24: ch = 8'h26;
        8'h25: ch = 8'h2A;
        8'h26: ch = 8'h28;
        8'h27: ch = shifted ? 8'h29 : 8'h30;
        8'h28: ch = CH_ENTER;
        8'h29: ch = 8'h1B;
        8'h2A: ch = CH_BACK;
        8'h2B: ch = 8'h09;
        8'h2C: ch = 8'h20;
        8'h2D: ch = shifted ? 8'h5F : 8'h2D;
        8'h2E: ch = shifted ? 8'h2B : 8'h3D;
        8'h2F: ch = shifted ? 8'h7B : 8'h5B;
        8'h30: ch = shifted ? 8'h7D : 8'h5D;
        8'h31: ch = shifted ? 8'h7C : 8'h5C;
        8'h33: ch = shifted ? 8'h3A : 8'h3B;
        8'h34: ch = shifted ? 8'h22 : 8'h27;
        8'h35: ch = shifted ? 8'h7E : 8'h60;
        8'h36: ch = shifted ? 8'h3C : 8'h2C;
        8'h37: ch = shifted ? 8'h3E : 8'h2E;
        8'h38: ch = shifted ? 8'h3F : 8'h2F;
        8'h43: ch = shifted ? 8'h6B : CH_NONE;
        default: ch = CH_NONE;
      endcase
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kle_ram.sv =====
`default_nettype none
module kle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/kle_ctrl.sv =====
`default_nettype none
module kle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  output kle_pkg::kle_cmd_t cmd,
  input  kle_pkg::kle_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_PUT   = 8'b0001_0000,
    S_CRD   = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_ready    = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_read) begin
          state_next = S_OUT;
        end else if (sts.edit) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_CRD;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_CRD;
      end
      S_CRD: begin
        cmd.crd    = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // The result register is free, or is emptied in this same cycle.
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/kle_dp.sv =====
`default_nettype none
module kle_dp #(
  parameter int MAX_LINES    = kle_pkg::MAX_LINES_DEF,
  parameter int LINE_CHARS   = kle_pkg::LINE_CHARS_DEF,
  parameter int WINDOW_LINES = kle_pkg::WINDOW_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kle_pkg::kle_cmd_t              cmd,
  output kle_pkg::kle_sts_t              sts,
  input  logic                           in_req,
  input  logic [kle_pkg::MOD_W-1:0]      in_mod,
  input  logic [kle_pkg::KEY_W-1:0]      in_key,
  input  logic [kle_pkg::RLINE_W-1:0]    in_rline,
  input  logic [kle_pkg::RCOL_W-1:0]     in_rcol,
  output logic [kle_pkg::ROW_W-1:0]      cursor_row,
  output logic [kle_pkg::COL_W-1:0]      cursor_column,
  output logic [kle_pkg::ROW_W-1:0]      top_row,
  output logic [kle_pkg::COUNT_W-1:0]    line_count,
  output logic [kle_pkg::CHAR_W-1:0]     cell_char,
  output logic [kle_pkg::COL_W-1:0]      cell_line_length
);

  localparam int RW     = $clog2(MAX_LINES);
  localparam int CW     = $clog2(LINE_CHARS + 1);
  localparam int LUW    = $clog2(MAX_LINES + 1);
  localparam int CDEPTH = MAX_LINES * LINE_CHARS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int WLW    = $clog2(WINDOW_LINES + 1);
  localparam int SW     = ((RW > WLW) ? RW : WLW) + 1;

  // Captured item.
  logic                           req_q;
  logic [kle_pkg::MOD_W-1:0]      mod_q;
  logic [kle_pkg::KEY_W-1:0]      key_q;
  logic [kle_pkg::RLINE_W-1:0]    rl_q;
  logic [kle_pkg::RCOL_W-1:0]     rc_q;

  // Editor state.
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic [RW-1:0]  top;
  logic [LUW-1:0] lines_used;
  logic [MAX_LINES-1:0] len_vld;
  logic           len_rvld;

  // Edit and line shift.
  logic                        edit_ins;
  logic [kle_pkg::CHAR_W-1:0]  edit_ch;
  logic [CW-1:0]               edit_len;
  logic [CW-1:0]               rd_dst;
  logic [CW-1:0]               wr_dst;
  logic                        pend;
  logic [CW-1:0]               left;

  logic [kle_pkg::CHAR_W-1:0]  cell_res;
  logic [CW-1:0]               clen_res;

  // Memory ports.
  logic                        c_we;
  logic [CAW-1:0]              c_waddr;
  logic [kle_pkg::CHAR_W-1:0]  c_wdata;
  logic [CAW-1:0]              c_raddr;
  logic [kle_pkg::CHAR_W-1:0]  c_rdata;
  logic                        l_we;
  logic [RW-1:0]               l_waddr;
  logic [CW-1:0]               l_wdata;
  logic [RW-1:0]               l_raddr;
  logic [CW-1:0]               l_rdata;

  logic [CAW-1:0] row_base;
  logic [CW-1:0]  src;
  logic [CW-1:0]  len_cur;
  logic           rl_ok;
  logic           rc_ok;
  logic [RW-1:0]  req_row;
  logic [CAW-1:0] req_caddr;

  // Key decode results.
  logic                        shifted;
  logic [kle_pkg::CHAR_W-1:0]  mapped;
  logic                        row_has_next;
  logic [RW-1:0]               ex_row;
  logic [CW-1:0]               ex_col;
  logic [RW-1:0]               ex_top;
  logic [LUW-1:0]              ex_lu;
  logic                        ex_edit;
  logic                        ex_ins;

  // Read request results.
  logic [CW-1:0]               clen_v;
  logic [kle_pkg::CHAR_W-1:0]  cell_v;

  // Clamp and scroll.
  logic [CW-1:0] col_c;
  logic [SW-1:0] rowx;
  logic [SW-1:0] topx;
  logic [SW-1:0] t1;
  logic [SW-1:0] t2;

  kle_ram #(
    .WIDTH (kle_pkg::CHAR_W),
    .DEPTH (CDEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  kle_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_LINES)
  ) u_len_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign row_base = CAW'(cur_row) * CAW'(LINE_CHARS);
  assign src      = edit_ins ? (rd_dst - CW'(1)) : (rd_dst + CW'(1));
  // A line never written since reset reads as empty.
  assign len_cur  = len_rvld ? l_rdata : '0;

  assign rl_ok     = (32'(rl_q) < MAX_LINES);
  assign rc_ok     = (32'(rc_q) < LINE_CHARS);
  assign req_row   = rl_ok ? RW'(rl_q) : '0;
  assign req_caddr = (rl_ok && rc_ok) ?
                     (CAW'(req_row) * CAW'(LINE_CHARS) + CAW'(rc_q)) : '0;

  assign c_raddr = cmd.shift ? (row_base + CAW'(src)) : req_caddr;
  assign l_raddr = (cmd.fetch && req_q) ? req_row : cur_row;

  assign c_we    = (cmd.shift && pend) || (cmd.put && edit_ins);
  assign c_waddr = row_base + CAW'(cmd.shift ? wr_dst : cur_col);
  assign c_wdata = cmd.shift ? c_rdata : edit_ch;
  assign l_we    = cmd.put;
  assign l_waddr = cur_row;
  assign l_wdata = edit_ins ? (edit_len + CW'(1)) : (edit_len - CW'(1));

  assign sts.is_read    = req_q;
  assign sts.edit       = ex_edit;
  assign sts.shift_done = (left == '0) && !pend;

  assign shifted      = |(mod_q & kle_pkg::SHIFT_MASK);
  assign mapped       = (key_q < kle_pkg::MAP_SIZE) ? kle_pkg::key_char(shifted, key_q)
                                                    : kle_pkg::CH_NONE;
  assign row_has_next = ((LUW+1)'(cur_row) + (LUW+1)'(1)) < (LUW+1)'(lines_used);

  always_comb begin
    ex_row  = cur_row;
    ex_col  = cur_col;
    ex_top  = top;
    ex_lu   = lines_used;
    ex_edit = 1'b0;
    ex_ins  = 1'b0;
    if (!req_q) begin
      case (key_q)
        kle_pkg::KEY_UP: begin
          if (cur_row != '0) begin
            ex_row = cur_row - RW'(1);
          end
        end
        kle_pkg::KEY_DOWN: begin
          if (row_has_next) begin
            ex_row = cur_row + RW'(1);
          end
        end
        kle_pkg::KEY_LEFT: begin
          if (cur_col != '0) begin
            ex_col = cur_col - CW'(1);
          end else if (cur_row != '0) begin
            // The column clamp later pulls this down to the line's end.
            ex_row = cur_row - RW'(1);
            ex_col = CW'(LINE_CHARS);
          end
        end
        kle_pkg::KEY_RIGHT: begin
          if (cur_col < len_cur) begin
            ex_col = cur_col + CW'(1);
          end else if (row_has_next) begin
            ex_row = cur_row + RW'(1);
            ex_col = '0;
          end
        end
        kle_pkg::KEY_ORIGIN: begin
          ex_row = '0;
          ex_col = '0;
          ex_top = '0;
        end
        default: begin
          if (mapped == kle_pkg::CH_ENTER) begin
            if (lines_used < LUW'(MAX_LINES)) begin
              ex_lu  = lines_used + LUW'(1);
              ex_row = cur_row + RW'(1);
              ex_col = '0;
            end
          end else if (mapped == kle_pkg::CH_BACK) begin
            if (cur_col != '0) begin
              ex_edit = 1'b1;
            end
          end else if (mapped != kle_pkg::CH_NONE) begin
            if (len_cur < CW'(LINE_CHARS)) begin
              ex_edit = 1'b1;
              ex_ins  = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign clen_v = rl_ok ? len_cur : '0;
  assign cell_v = (rc_ok && (32'(rc_q) < 32'(clen_v))) ? c_rdata : kle_pkg::CH_NONE;

  assign col_c = (cur_col > len_cur) ? len_cur : cur_col;
  assign rowx  = SW'(cur_row);
  assign topx  = SW'(top);
  assign t1    = (rowx >= topx + SW'(WINDOW_LINES)) ?
                 (rowx + SW'(1) - SW'(WINDOW_LINES)) : topx;
  assign t2    = (rowx < t1) ? rowx : t1;

  always_ff @(posedge clk) begin
    len_rvld <= len_vld[l_raddr];

    if (cmd.capture) begin
      req_q <= in_req;
      mod_q <= in_mod;
      key_q <= in_key;
      rl_q  <= in_rline;
      rc_q  <= in_rcol;
    end

    if (cmd.exec) begin
      edit_ins <= ex_ins;
      edit_ch  <= mapped;
      edit_len <= len_cur;
      rd_dst   <= ex_ins ? len_cur : (cur_col - CW'(1));
      cell_res <= req_q ? cell_v : kle_pkg::CH_NONE;
      clen_res <= req_q ? clen_v : '0;
    end

    if (cmd.shift && (left != '0)) begin
      rd_dst <= src;
      wr_dst <= rd_dst;
    end

    if (cmd.out_load) begin
      cursor_row       <= kle_pkg::ROW_W'(cur_row);
      cursor_column    <= kle_pkg::COL_W'(cur_col);
      top_row          <= kle_pkg::ROW_W'(top);
      line_count       <= kle_pkg::COUNT_W'(lines_used);
      cell_char        <= cell_res;
      cell_line_length <= kle_pkg::COL_W'(clen_res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      top        <= '0;
      lines_used <= LUW'(1);
      len_vld    <= '0;
      pend       <= 1'b0;
      left       <= '0;
    end else begin
      if (cmd.exec) begin
        cur_row    <= ex_row;
        cur_col    <= ex_col;
        top        <= ex_top;
        lines_used <= ex_lu;
        pend       <= 1'b0;
        // Insert and backspace move the same number of cells.
        left       <= ex_edit ? (len_cur - cur_col) : '0;
      end
      if (cmd.shift) begin
        if (left != '0) begin
          pend <= 1'b1;
          left <= left - CW'(1);
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.put) begin
        len_vld[cur_row] <= 1'b1;
        cur_col <= edit_ins ? (cur_col + CW'(1)) : (cur_col - CW'(1));
      end
      if (cmd.clamp) begin
        cur_col <= col_c;
        top     <= RW'(t2);
      end
    end
  end

`ifndef SYNTHESIS
  a_row_in_use: assert property (@(posedge clk) disable iff (rst)
    LUW'(cur_row) < lines_used)
    else $error("cursor row beyond the lines in use");

  a_lines_bound: assert property (@(posedge clk) disable iff (rst)
    (lines_used != '0) && (lines_used <= LUW'(MAX_LINES)))
    else $error("line count out of range");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    cur_col <= CW'(LINE_CHARS))
    else $error("cursor column beyond the line width");

  a_window: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp |=> (rowx >= topx) && (rowx < topx + SW'(WINDOW_LINES)))
    else $error("cursor row outside the window after scrolling");

  a_put_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.put && edit_ins) |-> (edit_len < CW'(LINE_CHARS)))
    else $error("insert into a full line");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/keyboard_line_editor.sv =====
`default_nettype none
// Line editor driven by keyboard reports. Each input transaction is either a key report
// (tuser low) or a request to read one stored character cell (tuser high), and each gives
// exactly one result transaction holding the cursor, the window top, the line count and,
// for a read, the cell and its line's length. Items are handled one at a time: a read passes
// from acceptance through the fetch, exec and out states, a key report that does not edit
// through fetch, exec, crd, clamp and out, and an insert or backspace adds the shift and put
// states, where the characters after the cursor move one place along the line through the
// character memory, one cell a cycle (at most LINE_CHARS - 1 of them).
// A new item is taken while the previous result still waits in the output register.
// Line lengths start empty after reset through per-line valid flags, so there is no
// clearing pass; cells past a line's length are never returned.
module keyboard_line_editor #(
  parameter int MAX_LINES    = kle_pkg::MAX_LINES_DEF,
  parameter int LINE_CHARS   = kle_pkg::LINE_CHARS_DEF,
  parameter int WINDOW_LINES = kle_pkg::WINDOW_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // modifier[7:0], keycode[15:8], read_line[21:16], read_col[26:22], zero fill
  input  logic [kle_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cursor_row[5:0], cursor_column[10:6], top_row[16:11], line_count[23:17],
  // cell_char[31:24], cell_line_length[36:32], zero fill
  output logic [kle_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  kle_pkg::kle_cmd_t cmd;
  kle_pkg::kle_sts_t sts;

  logic [kle_pkg::ROW_W-1:0]   cursor_row;
  logic [kle_pkg::COL_W-1:0]   cursor_column;
  logic [kle_pkg::ROW_W-1:0]   top_row;
  logic [kle_pkg::COUNT_W-1:0] line_count;
  logic [kle_pkg::CHAR_W-1:0]  cell_char;
  logic [kle_pkg::COL_W-1:0]   cell_line_length;

  kle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  kle_dp #(
    .MAX_LINES    (MAX_LINES),
    .LINE_CHARS   (LINE_CHARS),
    .WINDOW_LINES (WINDOW_LINES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_req           (s_axis_tuser),
    .in_mod           (s_axis_tdata[7:0]),
    .in_key           (s_axis_tdata[15:8]),
    .in_rline         (s_axis_tdata[21:16]),
    .in_rcol          (s_axis_tdata[26:22]),
    .cursor_row       (cursor_row),
    .cursor_column    (cursor_column),
    .top_row          (top_row),
    .line_count       (line_count),
    .cell_char        (cell_char),
    .cell_line_length (cell_line_length)
  );

  assign m_axis_tdata = {3'b000, cell_line_length, cell_char, line_count,
                         top_row, cursor_column, cursor_row};

endmodule
`default_nettype wire

// ===== tb/tb_keyboard_line_editor.sv =====
`timescale 1ns / 1ps

module tb_keyboard_line_editor;
  import kle_pkg::*;

  localparam int LINES       = MAX_LINES_DEF;
  localparam int CHARS       = LINE_CHARS_DEF;
  localparam int WINDOW      = WINDOW_LINES_DEF;
  localparam int MAP_ENTRIES = int'(MAP_SIZE);
  localparam int ITEMS       = 1700;
  localparam int QUIET_ITEMS = 200;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [KEY_W-1:0] KC_NONE      = 8'h00;
  localparam logic [KEY_W-1:0] KC_ENTER     = 8'h28;
  localparam logic [KEY_W-1:0] KC_BACKSPACE = 8'h2A;

  class editor_scoreboard;
    typedef struct {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   top;
      logic [COUNT_W-1:0] count;
      logic [CHAR_W-1:0]  glyph;
      logic [COL_W-1:0]   len;
    } editor_view_t;

    logic [CHAR_W-1:0] plain_tab [MAP_ENTRIES];
    logic [CHAR_W-1:0] shift_tab [MAP_ENTRIES];
    logic [CHAR_W-1:0] text [LINES][CHARS];
    int line_len [LINES];
    int row, col, top, used;
    editor_view_t expected_views[$];
    int failures;

    function new();
      foreach (plain_tab[i]) begin
        plain_tab[i] = CH_NONE;
        shift_tab[i] = CH_NONE;
      end
      place(1'b0, 4, "abcdefghijklmnopqrstuvwxyz");
      place(1'b1, 4, "ABCDEFGHIJKLMNOPQRSTUVWXYZ");
      place(1'b0, 30, "1234567890");
      place(1'b1, 30, "!@#$%^&*()");
      plain_tab[40] = CH_ENTER;
      plain_tab[41] = 8'h1B;
      plain_tab[42] = CH_BACK;
      plain_tab[43] = 8'h09;
      plain_tab[44] = 8'h20;
      for (int i = 40; i <= 44; i++) shift_tab[i] = plain_tab[i];
      place(1'b0, 45, "-=[]\\");
      place(1'b1, 45, "_+{}|");
      place(1'b0, 51, ";'~,./");
      // The grave accent is patched in afterwards to keep it out of a string.
      plain_tab[53] = 8'h60;
      place(1'b1, 51, ":\"~<>?");
      // A lone shifted entry sits past the punctuation block.
      shift_tab[67] = 8'h6B;
      foreach (line_len[i]) begin
        line_len[i] = 0;
        for (int j = 0; j < CHARS; j++) text[i][j] = CH_NONE;
      end
      row = 0;
      col = 0;
      top = 0;
      used = 1;
      failures = 0;
    endfunction

    function void place(bit shifted, int at, string s);
      for (int i = 0; i < s.len(); i++) begin
        if (shifted) shift_tab[at + i] = s[i];
        else plain_tab[at + i] = s[i];
      end
    endfunction

    function void type_char(logic [CHAR_W-1:0] ch);
      int n;
      n = line_len[row];
      if (ch == CH_ENTER) begin
        // A new line is only claimed at the end; the cursor line is not split.
        if (used < LINES) begin
          used++;
          row++;
          col = 0;
        end
      end else if (ch == CH_BACK) begin
        if (col > 0 && col <= n) begin
          for (int i = col - 1; i + 1 < n; i++) text[row][i] = text[row][i + 1];
          text[row][n - 1] = CH_NONE;
          line_len[row] = n - 1;
          col--;
        end
      end else if (n < CHARS && col <= n) begin
        for (int i = n; i > col; i--) text[row][i] = text[row][i - 1];
        text[row][col] = ch;
        line_len[row] = n + 1;
        col++;
      end
    endfunction

    function void press(logic [MOD_W-1:0] modifier, logic [KEY_W-1:0] keycode);
      logic [CHAR_W-1:0] ch;
      if (keycode >= KEY_ORIGIN && keycode <= KEY_UP) begin
        case (keycode)
          KEY_UP: begin
            if (row > 0) row--;
          end
          KEY_DOWN: begin
            if (row + 1 < used) row++;
          end
          KEY_LEFT: begin
            if (col > 0) begin
              col--;
            end else if (row > 0) begin
              row--;
              col = line_len[row];
            end
          end
          KEY_RIGHT: begin
            if (col < line_len[row]) begin
              col++;
            end else if (row + 1 < used) begin
              row++;
              col = 0;
            end
          end
          KEY_ORIGIN: begin
            row = 0;
            col = 0;
            top = 0;
          end
          default: ;
        endcase
      end else if (keycode < MAP_SIZE) begin
        ch = ((modifier & SHIFT_MASK) != 0) ? shift_tab[keycode] : plain_tab[keycode];
        if (ch != CH_NONE) type_char(ch);
      end
      if (col > line_len[row]) col = line_len[row];
      if (row >= top + WINDOW) top = row + 1 - WINDOW;
      if (row < top) top = row;
    endfunction

    function void note_input(logic req, logic [MOD_W-1:0] modifier, logic [KEY_W-1:0] keycode,
                             logic [RLINE_W-1:0] rline, logic [RCOL_W-1:0] rcol);
      editor_view_t v;
      v.glyph = CH_NONE;
      v.len = '0;
      if (req == REQ_KEY) begin
        press(modifier, keycode);
      end else if (rline < LINES) begin
        v.len = COL_W'(line_len[rline]);
        if (rcol < line_len[rline] && rcol < CHARS) v.glyph = text[rline][rcol];
      end
      v.row = ROW_W'(row);
      v.col = COL_W'(col);
      v.top = ROW_W'(top);
      v.count = COUNT_W'(used);
      expected_views.push_back(v);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      editor_view_t got;
      editor_view_t want;
      got.row   = data[5:0];
      got.col   = data[10:6];
      got.top   = data[16:11];
      got.count = data[23:17];
      got.glyph = data[31:24];
      got.len   = data[36:32];
      if (expected_views.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result transaction %h", data);
        return;
      end
      want = expected_views.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.top !== want.top ||
          got.count !== want.count || got.glyph !== want.glyph || got.len !== want.len) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected row %0d col %0d top %0d lines %0d char %h len %0d",
                   want.row, want.col, want.top, want.count, want.glyph, want.len);
          $display("          got      row %0d col %0d top %0d lines %0d char %h len %0d",
                   got.row, got.col, got.top, got.count, got.glyph, got.len);
        end
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  editor_scoreboard board = new();
  bit idle_on = 1'b1;
  int items_sent = 0;
  int stall_left = 0;
  int cycle_count = 0;

  keyboard_line_editor i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic req, input logic [MOD_W-1:0] modifier,
                           input logic [KEY_W-1:0] keycode, input logic [RLINE_W-1:0] rline,
                           input logic [RCOL_W-1:0] rcol);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {5'b0, rcol, rline, keycode, modifier};
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(req, modifier, keycode, rline, rcol);
    items_sent++;
    @(negedge clk);
  endtask

  // Unused fields of a transaction carry random values.
  task automatic press_key(input logic [MOD_W-1:0] modifier, input logic [KEY_W-1:0] keycode);
    send_item(REQ_KEY, modifier, keycode, RLINE_W'($urandom_range(0, 63)),
              RCOL_W'($urandom_range(0, 17)));
  endtask

  task automatic read_cell(input logic [RLINE_W-1:0] rline, input logic [RCOL_W-1:0] rcol);
    send_item(REQ_READ, MOD_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 255)),
              rline, rcol);
  endtask

  function automatic logic [KEY_W-1:0] printable_code();
    case ($urandom_range(0, 5))
      0: return 8'h29 + 8'(2 * $urandom_range(0, 1));
      1: return 8'h2C + 8'($urandom_range(0, 5));
      2: return 8'h33 + 8'($urandom_range(0, 5));
      3: return 8'h43;
      default: return 8'h04 + 8'($urandom_range(0, 35));
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] arrow_code();
    if ($urandom_range(0, 24) == 0) return KEY_ORIGIN;
    case ($urandom_range(0, 3))
      0: return KEY_LEFT;
      1: return KEY_RIGHT;
      2: return KEY_UP;
      default: return KEY_DOWN;
    endcase
  endfunction

  initial begin
    int run_len;
    int seq_kind;
    int next_switch;
    bit paused;
    next_switch = 150;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    read_cell(0, 0);
    press_key(8'hFF, KC_NONE);
    press_key(8'h00, 8'h04);
    press_key(8'h02, 8'h04);
    press_key(8'h20, 8'h05);
    press_key(8'hDD, 8'h1E);
    press_key(8'h02, 8'h43);
    press_key(8'h00, 8'h43);
    press_key(8'h00, 8'h32);
    press_key(8'hFF, 8'h49);
    press_key(8'h00, 8'h4B);
    press_key(8'h00, 8'h4E);
    press_key(8'h00, 8'h53);
    press_key(8'h22, 8'hFF);
    read_cell(0, 1);
    read_cell(0, 17);
    press_key(8'h00, KC_BACKSPACE);
    press_key(8'h00, KEY_ORIGIN);
    press_key(8'h00, KC_BACKSPACE);
    press_key(8'h00, KEY_LEFT);
    press_key(8'h00, KEY_UP);
    press_key(8'h00, KEY_DOWN);
    press_key(8'h00, KC_ENTER);
    press_key(8'h00, KEY_RIGHT);
    press_key(8'h00, KEY_LEFT);
    read_cell(63, 17);

    while (items_sent < ITEMS) begin
      if (items_sent >= next_switch) begin
        idle_on = (items_sent < ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
        next_switch += 150;
      end
      if (!paused && items_sent >= ITEMS / 2) begin
        // Hold off until the block has drained every outstanding transaction.
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (board.pending() != 0);
      end
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 35) begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 5);
        repeat (run_len) press_key(MOD_W'($urandom_range(0, 255)), printable_code());
      end else if (seq_kind < 45) begin
        repeat ($urandom_range(1, 6)) press_key(MOD_W'($urandom_range(0, 255)), KC_BACKSPACE);
      end else if (seq_kind < 57) begin
        repeat ($urandom_range(1, 2)) press_key(MOD_W'($urandom_range(0, 255)), KC_ENTER);
      end else if (seq_kind < 70) begin
        repeat ($urandom_range(1, 8)) press_key(MOD_W'($urandom_range(0, 255)), arrow_code());
      end else if (seq_kind < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) begin
            read_cell(RLINE_W'($urandom_range(0, 63)), RCOL_W'($urandom_range(0, 17)));
          end else begin
            read_cell(RLINE_W'($urandom_range(0, board.used - 1)),
                      RCOL_W'($urandom_range(0, 17)));
          end
        end
      end else begin
        press_key(MOD_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 255)));
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/kle_pkg.sv
rtl/core/kle_ram.sv
rtl/core/kle_ctrl.sv
rtl/core/kle_dp.sv
rtl/core/keyboard_line_editor.sv
tb/tb_keyboard_line_editor.sv
